// File: rtl/wfls_pkg.sv
package wfls_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned ShareW = 25;
  localparam int unsigned DivW   = 50;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [ShareW-1:0] OneShare = 25'd16777216;

  typedef enum logic [1:0] {
    CfgInput  = 2'd0,
    CfgOutput = 2'd1,
    CfgWork   = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    StIdle,
    StDivH,
    StDivW,
    StDivO,
    StStore,
    StSolveInit,
    StMid,
    StRead,
    StShareGo,
    StShareDiv,
    StShareAcc,
    StDecide,
    StOutRead,
    StOutGo,
    StOutDiv,
    StOutNorm,
    StOutWait,
    StOut
  } state_e;

endpackage

// File: rtl/wfls_ram.sv
module wfls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/wfls_div.sv
// Restoring divider, one quotient bit per cycle. Computes
// min(floor(num * 2^sh / den), limit), den == 0 giving limit.
module wfls_div import wfls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     num_i,
  input  logic [DivW-1:0]     den_i,
  input  logic                frac24_i,
  input  logic [TimeW-1:0]    limit_i,
  output logic                done_o,
  output logic [TimeW-1:0]    quot_o
);

  // Dividend is num shifted left by 32 or 24: at most 82 bits.
  localparam int unsigned NumW = DivW + 32;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, num_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [DivW-1:0]  den_q;
  logic [TimeW-1:0] lim_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d, zero_q;
  logic [DivW:0]    trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DivW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d  = frac24_i ? {8'd0, num_i, 24'd0} : {num_i, 32'd0};
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q  <= den_i;
      lim_q  <= limit_i;
      zero_q <= (den_i == '0);
    end
  end

  assign done_o = done_q;
  assign quot_o = (zero_q || quo_q > {{(NumW-TimeW){1'b0}}, lim_q}) ? lim_q
                : quo_q[TimeW-1:0];

endmodule

// File: rtl/water_filling_load_split.sv
// Load: each worker profile takes three serial divisions, after which it is
// stored and the input is ready again. The request that closes a set of N
// workers then runs SEARCH_STEPS bisection passes, one more pass for the share
// sum, and an output pass, stalled by out_ready_i, to emit the normalized shares.
// Reset clears the configuration registers, the set state and the controller;
// the worker memories hold nothing meaningful until written.
module water_filling_load_split import wfls_pkg::*; #(
  parameter int unsigned MAX_WORKERS  = 16,
  parameter int unsigned SEARCH_STEPS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [49:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [39:0]       link_rate_i,
  input  logic [49:0]       compute_rate_i,
  input  logic [24:0]       share_cap_i,
  input  logic              last_worker_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        worker_slot_o,
  output logic [24:0]       share_o,
  output logic [47:0]       finish_time_o,
  output logic              last_share_o
);

  localparam int unsigned AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned SW = $clog2(SEARCH_STEPS + 1);
  localparam int unsigned SumW = ShareW + NW;

  logic [39:0] in_size_q, out_size_q;
  logic [49:0] work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= '0;
      out_size_q <= '0;
      work_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInput:  in_size_q  <= cfg_data_i[39:0];
        CfgOutput: out_size_q <= cfg_data_i[39:0];
        CfgWork:   work_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [NW-1:0]     count_q, count_d;
  logic [TimeW-1:0]  least_q, least_d, full_q, full_d;
  logic [TimeW-1:0]  low_q, low_d, high_q, high_d, best_q, best_d, mid_q, mid_d;
  logic [TimeW-1:0]  h_q, h_d, kw_q, kw_d;
  logic [39:0]       link_q;
  logic [49:0]       comp_q;
  logic [24:0]       cap_q;
  logic              last_q;
  logic              final_q, final_d;
  logic [SW-1:0]     step_q, step_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ShareW-1:0] alpha_q, alpha_d;

  // Worker memories
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TimeW-1:0]  h_rd, k_rd;
  logic [ShareW-1:0] cap_rd;

  wfls_ram #(.Width(TimeW), .Depth(MAX_WORKERS)) u_start (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(h_q),
    .raddr_i(idx_q), .rdata_o(h_rd));
  wfls_ram #(.Width(TimeW), .Depth(MAX_WORKERS)) u_cost (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(kw_q),
    .raddr_i(idx_q), .rdata_o(k_rd));
  wfls_ram #(.Width(ShareW), .Depth(MAX_WORKERS)) u_cap (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(cap_q),
    .raddr_i(idx_q), .rdata_o(cap_rd));

  function automatic logic [TimeW-1:0] add_sat(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  // Divider
  logic             div_start, div_done, div_frac;
  logic [DivW-1:0]  div_num, div_den;
  logic [TimeW-1:0] div_lim, div_q;

  wfls_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .frac24_i(div_frac), .limit_i(div_lim), .done_o(div_done), .quot_o(div_q));

  // The memory read data is valid in the cycle after the address is presented.
  logic [TimeW-1:0] dt, full_time;
  logic             zero_share, sum_hit;
  assign dt         = mid_q - h_rd;
  assign zero_share = (mid_q <= h_rd);
  assign full_time  = add_sat(h_q, kw_q);
  assign sum_hit    = (sum_q >= SumW'(OneShare));

  logic [AW-1:0] last_idx;
  assign last_idx = AW'(count_q - 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (in_valid_i) state_d = StDivH;
      StDivH:      if (div_done) state_d = StDivW;
      StDivW:      if (div_done) state_d = StDivO;
      StDivO:      if (div_done) state_d = StStore;
      StStore:     state_d = last_q ? StSolveInit : StIdle;
      StSolveInit: state_d = (count_q == '0) ? StIdle : StMid;
      StMid:       state_d = StRead;
      StRead:      state_d = StShareGo;
      StShareGo:   state_d = zero_share ? StShareAcc : StShareDiv;
      StShareDiv:  if (div_done) state_d = StShareAcc;
      StShareAcc: begin
        if (idx_q == last_idx) state_d = final_q ? StOutRead : StDecide;
        else state_d = StRead;
      end
      StDecide:    state_d = (step_q == SW'(SEARCH_STEPS - 1)) ? StRead : StMid;
      StOutRead:   state_d = StOutGo;
      StOutGo:     state_d = zero_share ? StOutNorm : StOutDiv;
      StOutDiv:    if (div_done) state_d = StOutNorm;
      StOutNorm:   state_d = (sum_q == '0) ? StOut : StOutWait;
      StOutWait:   if (div_done) state_d = StOut;
      StOut:       if (out_ready_i) state_d = (idx_q == last_idx) ? StIdle : StOutRead;
      default:     state_d = StIdle;
    endcase
  end

  // Datapath control
  always_comb begin
    count_d = count_q; least_d = least_q; full_d = full_q;
    low_d = low_q; high_d = high_q; best_d = best_q; mid_d = mid_q;
    h_d = h_q; kw_d = kw_q; step_d = step_q; idx_d = idx_q;
    sum_d = sum_q; alpha_d = alpha_q; final_d = final_q;
    mem_we = 1'b0; mem_waddr = count_q[AW-1:0];
    div_start = 1'b0; div_num = '0; div_den = '0; div_frac = 1'b0; div_lim = TimeMax;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          div_start = 1'b1;
          div_num   = {10'd0, in_size_q};
          div_den   = {10'd0, link_rate_i};
        end
      end
      StDivH: begin
        if (div_done) begin
          h_d       = div_q;
          div_start = 1'b1;
          div_num   = work_q;
          div_den   = comp_q;
        end
      end
      StDivW: begin
        if (div_done) begin
          kw_d      = div_q;
          div_start = 1'b1;
          div_num   = {10'd0, out_size_q};
          div_den   = {10'd0, link_q};
        end
      end
      StDivO: begin
        if (div_done) kw_d = add_sat(kw_q, div_q);
      end
      StStore: begin
        // Profiles beyond the store are dropped, but a closing one still solves.
        if (count_q < NW'(MAX_WORKERS)) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (h_q < least_q) least_d = h_q;
          if (full_time > full_q) full_d = full_time;
        end
      end
      StSolveInit: begin
        low_d   = least_q;
        high_d  = add_sat(full_q, full_q);
        best_d  = add_sat(full_q, full_q);
        step_d  = '0;
        final_d = 1'b0;
        if (count_q == '0) begin
          least_d = TimeMax; full_d = '0;
        end
      end
      StMid: begin
        mid_d = low_q + ((high_q - low_q) >> 1);
        idx_d = '0;
        sum_d = '0;
      end
      StShareGo, StOutGo: begin
        if (zero_share) begin
          alpha_d = '0;
        end else begin
          div_start = 1'b1;
          div_num   = {2'b00, dt};
          div_den   = {2'b00, k_rd};
          div_frac  = 1'b1;
          div_lim   = {{(TimeW-ShareW){1'b0}}, cap_rd};
        end
      end
      StShareDiv, StOutDiv: begin
        if (div_done) alpha_d = div_q[ShareW-1:0];
      end
      StShareAcc: begin
        sum_d = sum_q + SumW'(alpha_q);
        if (idx_q == last_idx) idx_d = '0;
        else idx_d = idx_q + 1'b1;
      end
      StDecide: begin
        if (sum_hit) begin
          best_d = mid_q; high_d = mid_q;
        end else begin
          low_d = mid_q;
        end
        step_d = step_q + 1'b1;
        // After the last pass one more sweep sums the shares at the best time.
        if (step_q == SW'(SEARCH_STEPS - 1)) begin
          final_d = 1'b1;
          mid_d   = sum_hit ? mid_q : best_q;
          idx_d   = '0;
          sum_d   = '0;
        end
      end
      StOutNorm: begin
        if (sum_q != '0) begin
          div_start = 1'b1;
          div_num   = {{(DivW-ShareW){1'b0}}, alpha_q};
          div_den   = {{(DivW-SumW){1'b0}}, sum_q};
          div_frac  = 1'b1;
          div_lim   = TimeMax;
        end
      end
      StOutWait: begin
        if (div_done) alpha_d = div_q[ShareW-1:0];
      end
      StOut: begin
        if (out_ready_i) begin
          if (idx_q == last_idx) begin
            count_d = '0; least_d = TimeMax; full_d = '0; idx_d = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      least_q <= TimeMax;
      full_q  <= '0;
      step_q  <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      least_q <= least_d;
      full_q  <= full_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d; high_q <= high_d; best_q <= best_d; mid_q <= mid_d;
    h_q <= h_d; kw_q <= kw_d; sum_q <= sum_d;
    alpha_q <= alpha_d;
    if (state_q == StIdle && in_valid_i) begin
      link_q <= link_rate_i;
      comp_q <= compute_rate_i;
      cap_q  <= share_cap_i;
      last_q <= last_worker_i;
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign worker_slot_o = 4'(idx_q);
  assign share_o       = alpha_q;
  assign finish_time_o = best_q;
  assign last_share_o  = (idx_q == last_idx);

endmodule
